// ===== rtl/modular_matrix_power_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MODULAR_MATRIX_POWER_UNIT_MACROS_SVH
`define MODULAR_MATRIX_POWER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mmp_pkg.sv =====
package mmp_pkg;

    // Matrix geometry.
    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int ENTRY_W = 30;
    localparam int EXP_W   = 31;
    localparam int SIZE_W  = 4;

    // Modular arithmetic constants.
    localparam logic [ENTRY_W-1:0] MODULUS = 30'd1000000007;
    localparam logic [EXP_W-1:0] BARRETT_MU =
        EXP_W'((64'd1 << (2 * ENTRY_W)) / 64'(MODULUS));

    // Pipeline depth of one cell and of the whole chain.
    localparam int CELL_LAT  = 6;
    localparam int CHAIN_LAT = MAX_DIM + CELL_LAT;
    localparam int DRAIN_W   = $clog2(CHAIN_LAT);

    typedef enum logic {
        KIND_LOAD  = 1'b0,
        KIND_POWER = 1'b1
    } mmp_kind_t;

    typedef struct packed {
        mmp_kind_t          kind;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [ENTRY_W-1:0] entry_in;
        logic [EXP_W-1:0]   exponent;
    } mmp_in_t;

    typedef struct packed {
        logic [IDX_W-1:0]   out_row;
        logic [IDX_W-1:0]   out_col;
        logic [ENTRY_W-1:0] entry_out;
        logic               last;
    } mmp_out_t;

    // Position tag that walks down the cell chain.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] ri;
        logic [IDX_W-1:0] cj;
    } mmp_tag_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic               use_acc;
        logic               wr_base;
        logic               wr_acc;
        logic               wr_ident;
        logic [IDX_W-1:0]   wr_row;
        logic [IDX_W-1:0]   wr_col;
        logic [ENTRY_W-1:0] wr_data;
        logic [IDX_W-1:0]   rd_row;
    } mmp_cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_ISSUE,
        ST_DRAIN,
        ST_COPY,
        ST_COPY_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } mmp_state_t;

endpackage

// ===== rtl/mmp_cell.sv =====
module mmp_cell
    import mmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IDX_W-1:0]   cell_idx,
    input  logic               active,
    input  mmp_cell_ctl_t      ctl,
    input  mmp_tag_t           tag_in,
    output mmp_tag_t           tag_out,
    input  logic [ENTRY_W-1:0] sum_in,
    output logic [ENTRY_W-1:0] sum_out,
    output logic [ENTRY_W-1:0] acc_rd
);

    // Cell k holds row k and column k of the base matrix and column k of the
    // accumulator, so it supplies the k-th term of every dot product.
    logic [ENTRY_W-1:0] base_row [MAX_DIM];
    logic [ENTRY_W-1:0] base_col [MAX_DIM];
    logic [ENTRY_W-1:0] acc_col  [MAX_DIM];

    logic [ENTRY_W-1:0]   acc_rd_reg;
    logic [ENTRY_W-1:0]   a_reg;
    logic [ENTRY_W-1:0]   b_reg;
    logic [2*ENTRY_W-1:0] prod_reg;
    logic [31:0]          low_reg;
    logic [EXP_W-1:0]     quot_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          rem1_reg;
    logic [ENTRY_W-1:0]   term_reg;
    logic [ENTRY_W-1:0]   sum_reg;
    mmp_tag_t             tag_reg;

    logic [2*EXP_W-1:0]     barrett_prod;
    logic [EXP_W+ENTRY_W-1:0] quot_mod;
    logic [ENTRY_W:0]       sum_wide;

    // Quotient estimate and modulus multiple for the Barrett reduction, and the widened running sum.
    always_comb
    begin
        barrett_prod = (2*EXP_W)'(prod_reg[2*ENTRY_W-1:ENTRY_W-1]) * (2*EXP_W)'(BARRETT_MU);
        quot_mod     = (EXP_W+ENTRY_W)'(quot_reg) * (EXP_W+ENTRY_W)'(MODULUS);
        sum_wide     = (ENTRY_W+1)'(sum_in) + (ENTRY_W+1)'(term_reg);
    end

    // Local storage writes and the emission read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_base)
        begin
            if (ctl.wr_row == cell_idx)
            begin
                base_row[ctl.wr_col] <= ctl.wr_data;
            end
            if (ctl.wr_col == cell_idx)
            begin
                base_col[ctl.wr_row] <= ctl.wr_data;
            end
        end
        if (ctl.wr_ident)
        begin
            for (int m = 0; m < MAX_DIM; m++)
            begin
                acc_col[m] <= (IDX_W'(m) == cell_idx) ? ENTRY_W'(1) : '0;
            end
        end
        else if (ctl.wr_acc && (ctl.wr_col == cell_idx))
        begin
            acc_col[ctl.wr_row] <= ctl.wr_data;
        end
        acc_rd_reg <= acc_col[ctl.rd_row];
    end

    // Multiply, reduce and add pipeline. Cells beyond the size in use feed zero.
    always_ff @(posedge clk)
    begin
        if (active)
        begin
            a_reg <= ctl.use_acc ? acc_col[tag_in.ri] : base_col[tag_in.ri];
            b_reg <= base_row[tag_in.cj];
        end
        else
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        prod_reg <= (2*ENTRY_W)'(a_reg) * (2*ENTRY_W)'(b_reg);
        quot_reg <= barrett_prod[2*EXP_W-1:EXP_W];
        low_reg  <= prod_reg[31:0];
        rem_reg  <= low_reg - quot_mod[31:0];
        rem1_reg <= (rem_reg >= 32'(MODULUS)) ? rem_reg - 32'(MODULUS) : rem_reg;
        term_reg <= (rem1_reg >= 32'(MODULUS)) ? ENTRY_W'(rem1_reg - 32'(MODULUS))
                                               : rem1_reg[ENTRY_W-1:0];
        sum_reg  <= (sum_wide >= (ENTRY_W+1)'(MODULUS))
                    ? ENTRY_W'(sum_wide - (ENTRY_W+1)'(MODULUS))
                    : sum_wide[ENTRY_W-1:0];
    end

    // The position tag moves one cell per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    assign tag_out = tag_reg;
    assign sum_out = sum_reg;
    assign acc_rd  = acc_rd_reg;

endmodule

// ===== rtl/modular_matrix_power_unit.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid, in_stall  | in_data (mmp_in_t)
// out     | output    | out_valid, out_stall| out_data (mmp_out_t)
// cfg     | input     | cfg_wr_en           | cfg_wr_data (size in use)
//
// A power beat runs up to two matrix products per exponent bit; each
// product issues its n*n entries into the cell chain, drains the chain,
// copies the n*n results back into the cells and then finishes.
// Emission then reads and sends each entry in turn, waiting out output stalls.
// Reset is asynchronous and clears control only; matrices need loading.
// in_stall stays high from a power beat until its last entry is loaded.
module modular_matrix_power_unit
    import mmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mmp_in_t           in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output mmp_out_t          out_data,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data
);

    mmp_state_t         state_reg, state_next;
    logic [SIZE_W-1:0]  size_reg;
    logic [EXP_W-1:0]   pw_reg, pw_next;
    logic               mul_done_reg, mul_done_next;
    logic               use_acc_reg, use_acc_next;
    logic [IDX_W-1:0]   i_cnt_reg, i_cnt_next;
    logic [IDX_W-1:0]   j_cnt_reg, j_cnt_next;
    logic [DRAIN_W-1:0] drain_reg, drain_next;
    logic               out_valid_reg, out_valid_next;
    mmp_out_t           out_reg, out_next;
    logic               out_load;
    logic               issue_vld;
    logic               cp_vld_reg;
    logic [IDX_W-1:0]   cp_row_reg, cp_col_reg;
    logic [ENTRY_W-1:0] scr_q_reg;

    logic [ENTRY_W-1:0] scratch_mem [MAX_DIM*MAX_DIM];
    mmp_tag_t           dl_reg [CELL_LAT];

    logic [IDX_W-1:0]   nm1;
    logic               last_col, last_entry;
    logic [IDX_W-1:0]   i_adv, j_adv;
    logic [ENTRY_W-1:0] load_val;
    mmp_cell_ctl_t      ctl;
    mmp_tag_t           tag_link [MAX_DIM+1];
    logic [ENTRY_W-1:0] sum_link [MAX_DIM+1];
    logic [ENTRY_W-1:0] acc_rd   [MAX_DIM];

    // Effective dimension minus one, with out-of-range sizes clamped.
    always_comb
    begin
        if (size_reg == '0)
        begin
            nm1 = '0;
        end
        else if (size_reg > SIZE_W'(MAX_DIM))
        begin
            nm1 = IDX_W'(MAX_DIM - 1);
        end
        else
        begin
            nm1 = IDX_W'(size_reg - SIZE_W'(1));
        end
    end

    // Row-major walk over the leading n by n block.
    assign last_col   = (j_cnt_reg == nm1);
    assign last_entry = last_col && (i_cnt_reg == nm1);
    assign j_adv      = last_col ? '0 : j_cnt_reg + IDX_W'(1);
    assign i_adv      = last_entry ? '0 : (last_col ? i_cnt_reg + IDX_W'(1) : i_cnt_reg);

    // A loaded entry at or above the modulus loses one modulus.
    assign load_val = (in_data.entry_in >= MODULUS) ? in_data.entry_in - MODULUS
                                                    : in_data.entry_in;

    // Sequencer: next state, counters, cell control and the output beat.
    always_comb
    begin
        state_next     = state_reg;
        pw_next        = pw_reg;
        mul_done_next  = mul_done_reg;
        use_acc_next   = use_acc_reg;
        i_cnt_next     = i_cnt_reg;
        j_cnt_next     = j_cnt_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        out_load       = 1'b0;
        in_stall       = (state_reg != ST_IDLE);
        issue_vld      = 1'b0;

        ctl          = '0;
        ctl.use_acc  = use_acc_reg;
        ctl.rd_row   = i_cnt_reg;
        if (cp_vld_reg)
        begin
            ctl.wr_base = !use_acc_reg;
            ctl.wr_acc  = use_acc_reg;
            ctl.wr_row  = cp_row_reg;
            ctl.wr_col  = cp_col_reg;
            ctl.wr_data = scr_q_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.kind == KIND_LOAD)
                    begin
                        ctl.wr_base = 1'b1;
                        ctl.wr_row  = in_data.row;
                        ctl.wr_col  = in_data.col;
                        ctl.wr_data = load_val;
                    end
                    else
                    begin
                        ctl.wr_ident  = 1'b1;
                        pw_next       = in_data.exponent;
                        mul_done_next = 1'b0;
                        i_cnt_next    = '0;
                        j_cnt_next    = '0;
                        state_next    = (in_data.exponent == '0) ? ST_EMIT_RD : ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                i_cnt_next = '0;
                j_cnt_next = '0;
                if (pw_reg == '0)
                begin
                    state_next = ST_EMIT_RD;
                end
                else if (pw_reg[0] && !mul_done_reg)
                begin
                    use_acc_next = 1'b1;
                    state_next   = ST_ISSUE;
                end
                else if (pw_reg[EXP_W-1:1] != '0)
                begin
                    use_acc_next = 1'b0;
                    state_next   = ST_ISSUE;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_ISSUE:
            begin
                issue_vld  = 1'b1;
                i_cnt_next = i_adv;
                j_cnt_next = j_adv;
                if (last_entry)
                begin
                    drain_next = DRAIN_W'(CHAIN_LAT - 1);
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = ST_COPY;
                end
                else
                begin
                    drain_next = drain_reg - DRAIN_W'(1);
                end
            end
            ST_COPY:
            begin
                i_cnt_next = i_adv;
                j_cnt_next = j_adv;
                if (last_entry)
                begin
                    state_next = ST_COPY_END;
                end
            end
            ST_COPY_END:
            begin
                if (use_acc_reg)
                begin
                    mul_done_next = 1'b1;
                end
                else
                begin
                    pw_next       = pw_reg >> 1;
                    mul_done_next = 1'b0;
                end
                state_next = ST_DECIDE;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_next       = '{out_row: i_cnt_reg, out_col: j_cnt_reg,
                                       entry_out: acc_rd[j_cnt_reg], last: last_entry};
                    ctl.wr_base    = 1'b1;
                    ctl.wr_row     = i_cnt_reg;
                    ctl.wr_col     = j_cnt_reg;
                    ctl.wr_data    = acc_rd[j_cnt_reg];
                    i_cnt_next     = i_adv;
                    j_cnt_next     = j_adv;
                    state_next     = last_entry ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_W'(MAX_DIM);
            pw_reg        <= '0;
            mul_done_reg  <= 1'b0;
            use_acc_reg   <= 1'b0;
            i_cnt_reg     <= '0;
            j_cnt_reg     <= '0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
            cp_vld_reg    <= 1'b0;
            for (int m = 0; m < CELL_LAT; m++)
            begin
                dl_reg[m] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pw_reg        <= pw_next;
            mul_done_reg  <= mul_done_next;
            use_acc_reg   <= use_acc_next;
            i_cnt_reg     <= i_cnt_next;
            j_cnt_reg     <= j_cnt_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
            cp_vld_reg    <= (state_reg == ST_COPY);
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            dl_reg[0] <= tag_link[MAX_DIM];
            for (int m = 1; m < CELL_LAT; m++)
            begin
                dl_reg[m] <= dl_reg[m-1];
            end
        end
    end

    // Output beat register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // Scratch memory: products land here, then get swept into the cells.
    always_ff @(posedge clk)
    begin
        if (dl_reg[CELL_LAT-1].vld)
        begin
            scratch_mem[{dl_reg[CELL_LAT-1].ri, dl_reg[CELL_LAT-1].cj}] <= sum_link[MAX_DIM];
        end
        scr_q_reg  <= scratch_mem[{i_cnt_reg, j_cnt_reg}];
        cp_row_reg <= i_cnt_reg;
        cp_col_reg <= j_cnt_reg;
    end

    // Chain of dot-product cells.
    assign tag_link[0] = '{vld: issue_vld, ri: i_cnt_reg, cj: j_cnt_reg};
    assign sum_link[0] = '0;

    for (genvar k = 0; k < MAX_DIM; k++)
    begin : g_cell
        mmp_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(k)),
            .active   (IDX_W'(k) <= nm1),
            .ctl      (ctl),
            .tag_in   (tag_link[k]),
            .tag_out  (tag_link[k+1]),
            .sum_in   (sum_link[k]),
            .sum_out  (sum_link[k+1]),
            .acc_rd   (acc_rd[k])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== rtl/mmp_checker.sv =====
`include "modular_matrix_power_unit_macros.svh"

module mmp_checker
    import mmp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input mmp_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input mmp_out_t out_data
);

    // A stalled result beat stays put.
    `MMP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "out beat changed while stalled")

    // A power beat makes the block busy at once.
    `MMP_ASSERT_NXT(a_power_busy, in_valid && !in_stall && in_data.kind == KIND_POWER, in_stall, "power beat did not stall input")

    // A load beat on a quiet output brings no result.
    `MMP_ASSERT_NXT(a_load_quiet, in_valid && !in_stall && in_data.kind == KIND_LOAD && !out_valid, !out_valid, "load beat produced a result")

    // While a stream is mid-matrix the input stays stalled.
    `MMP_ASSERT_IMP(a_stream_busy, out_valid && !out_data.last, in_stall, "input open during result stream")

endmodule

bind modular_matrix_power_unit mmp_checker u_mmp_checker (.*);
